>>> rtl/lru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and constants of the fully associative LRU cache model.
// ----------------------------------------------------------------------------
package lru_pkg;

   localparam int unsigned CAP_W = 11;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1000;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] block_number;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] read_count;
      logic [31:0] write_count;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/lru_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lru_ram #(
   parameter int unsigned AW = 10,
   parameter int unsigned DW = 42
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/lru_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_engine
// Sequencer: a read scans the store for the tag and the LRU slot, then sweeps
// it again to age ranks and write the MRU entry; a clear empties the cache.
// ----------------------------------------------------------------------------
module lru_engine #(
   parameter int unsigned MAX_ENTRIES = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [10:0]             capacity,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire lru_pkg::req_type        req_data,
   output logic                         res_valid,
   input  wire logic                    res_ready,
   output lru_pkg::rsp_type             res_data
);
   import lru_pkg::*;

   localparam int unsigned AW   = $clog2(MAX_ENTRIES);
   localparam int unsigned CW   = AW + 1;
   localparam int unsigned DW   = 32 + AW;
   localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic [31:0]       tag_ff, tag_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     hit_slot_ff, hit_slot_in;
   logic [AW-1:0]     hit_rank_ff, hit_rank_in;
   logic [AW-1:0]     lru_slot_ff, lru_slot_in;
   logic [AW-1:0]     target_ff, target_in;
   logic [AW-1:0]     old_ff, old_in;
   logic [CW-1:0]     len_ff, len_in;
   logic              grow_ff, grow_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic              hit_ff, hit_in;
   logic [31:0]       hits_ff, hits_in;
   logic [31:0]       misses_ff, misses_in;
   logic [31:0]       reads_ff, reads_in;
   logic [31:0]       writes_ff, writes_in;

   logic              rd_en;
   logic [DW-1:0]     rd_data;
   logic              wr_en;
   logic [DW-1:0]     wr_data;
   logic [31:0]       rd_tag;
   logic [AW-1:0]     rd_rank;
   logic [CMPW-1:0]   eff_cap;
   logic              evict;

   assign rd_tag  = rd_data[DW-1:AW];
   assign rd_rank = rd_data[AW-1:0];

   // capacity zero acts as one, above the store size saturates
   always_comb begin
      if (capacity == '0) begin
         eff_cap = CMPW'(1);
      end else if (CMPW'(capacity) > CMPW'(MAX_ENTRIES)) begin
         eff_cap = CMPW'(MAX_ENTRIES);
      end else begin
         eff_cap = CMPW'(capacity);
      end
   end

   assign evict = (CMPW'(fill_ff) >= eff_cap) && (fill_ff != '0);

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      tag_in      = tag_ff;
      found_in    = found_ff;
      hit_slot_in = hit_slot_ff;
      hit_rank_in = hit_rank_ff;
      lru_slot_in = lru_slot_ff;
      target_in   = target_ff;
      old_in      = old_ff;
      len_in      = len_ff;
      grow_in     = grow_ff;
      fill_in     = fill_ff;
      hit_in      = hit_ff;
      hits_in     = hits_ff;
      misses_in   = misses_ff;
      reads_in    = reads_ff;
      writes_in   = writes_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_data     = rd_data;
      req_ready   = (state_ff == ST_IDLE);
      res_valid   = (state_ff == ST_DONE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hit_in = 1'b0;
               if (req_data.op == OP_CLEAR) begin
                  fill_in   = '0;
                  hits_in   = '0;
                  misses_in = '0;
                  reads_in  = '0;
                  writes_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  tag_in   = req_data.block_number;
                  found_in = 1'b0;
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_en = (idx_ff != fill_ff);
            if (rd_en) begin
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if (!found_ff && (rd_tag == tag_ff)) begin
                  found_in    = 1'b1;
                  hit_slot_in = rd_idx_ff;
                  hit_rank_in = rd_rank;
               end
               if (CW'(rd_rank) == (fill_ff - CW'(1))) begin
                  lru_slot_in = rd_idx_ff;
               end
            end
            if (!rd_en && !rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            idx_in   = '0;
            reads_in = reads_ff + 32'd1;
            state_in = ST_UPDATE;
            if (found_ff) begin
               hit_in    = 1'b1;
               hits_in   = hits_ff + 32'd1;
               target_in = hit_slot_ff;
               old_in    = hit_rank_ff;
               len_in    = fill_ff;
               grow_in   = 1'b0;
            end else begin
               misses_in = misses_ff + 32'd1;
               writes_in = writes_ff + 32'd1;
               if (evict) begin
                  target_in = lru_slot_ff;
                  old_in    = AW'(fill_ff - CW'(1));
                  len_in    = fill_ff;
                  grow_in   = 1'b0;
               end else begin
                  target_in = fill_ff[AW-1:0];
                  old_in    = fill_ff[AW-1:0];
                  len_in    = fill_ff + CW'(1);
                  grow_in   = 1'b1;
               end
            end
         end
         ST_UPDATE: begin
            rd_en = (idx_ff != len_ff);
            if (rd_en) begin
               idx_in = idx_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               wr_en = 1'b1;
               if (rd_idx_ff == target_ff) begin
                  wr_data = {tag_ff, AW'(0)};
               end else if (rd_rank < old_ff) begin
                  wr_data = {rd_tag, rd_rank + AW'(1)};
               end else begin
                  wr_data = rd_data;
               end
            end
            if (!rd_en && !rd_vld_ff) begin
               if (grow_ff) begin
                  fill_in = fill_ff + CW'(1);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_vld_in = rd_en;
   assign rd_idx_in = idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
         fill_ff   <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
         reads_ff  <= '0;
         writes_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         fill_ff   <= fill_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         reads_ff  <= reads_in;
         writes_ff <= writes_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      tag_ff      <= tag_in;
      found_ff    <= found_in;
      hit_slot_ff <= hit_slot_in;
      hit_rank_ff <= hit_rank_in;
      lru_slot_ff <= lru_slot_in;
      target_ff   <= target_in;
      old_ff      <= old_in;
      len_ff      <= len_in;
      grow_ff     <= grow_in;
      hit_ff      <= hit_in;
   end

   assign res_data.hit         = hit_ff;
   assign res_data.hit_count   = hits_ff;
   assign res_data.miss_count  = misses_ff;
   assign res_data.read_count  = reads_ff;
   assign res_data.write_count = writes_ff;

   lru_ram #(
      .AW (AW),
      .DW (DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_ENTRIES))
      else $error("fill count above store size");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_UPDATE))
      else $error("entry write outside update sweep");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (fill_ff == $past(fill_ff))
         || (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("fill count changed by more than one");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while busy");

endmodule
`default_nettype wire

>>> rtl/lru_cache_hit_miss_model.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_cache_hit_miss_model
// Fully associative cache hit/miss model with LRU replacement and counters.
//
//   channel  ports            direction  handshake
//   request  req_*            in         valid / ready
//   response rsp_*            out        valid / ready
//   control  csr_*            in         write enable, no wait
//
// A read item runs one scan of the filled entries and one rank update
// sweep, which also covers the new slot when the item adds an entry; both
// go one entry per cycle through the single read port of the entry store,
// each followed by a drain of the read pipeline. A clear item runs no sweep.
// No new item is taken until the current one is through.
// Reset empties the cache and zeroes the counters; no clearing pass is run.
// The response register lets the next item enter while a result waits.
// ----------------------------------------------------------------------------
module lru_cache_hit_miss_model #(
   parameter int unsigned MAX_ENTRIES = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lru_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lru_pkg::rsp_type      rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [10:0]      csr_wr_data
);
   import lru_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic             res_valid;
   logic             res_ready;
   rsp_type          res_data;

   assign res_ready    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (res_valid && res_ready) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lru_engine #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

endmodule
`default_nettype wire
